// File: hw/rtl/rtu_pkg.sv
// ----------------------------------------------------------------------------
// RTU receiver package
// Shared widths, codes, configuration record and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package rtu_pkg;

  localparam int ReqW   = 3;
  localparam int ByteW  = 8;
  localparam int EventW = 3;
  localparam int LenW   = 9;
  localparam int TickW  = 16;
  localparam int CrcW   = 16;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  localparam int MaxFrameDefault = 256;
  localparam int MinFrameDefault = 4;

  localparam logic [CrcW-1:0]  CrcInit  = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly  = 16'hA001;
  localparam logic [TickW-1:0] TickMax  = 16'hFFFF;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK  = 3'd0,
    REQ_BYTE  = 3'd1,
    REQ_ERROR = 3'd2,
    REQ_START = 3'd3,
    REQ_STOP  = 3'd4
  } req_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE         = 3'd0,
    EV_GOOD         = 3'd1,
    EV_BAD          = 3'd2,
    EV_WAIT_TIMEOUT = 3'd3,
    EV_LINE_ERROR   = 3'd4
  } event_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_GUARD_TICKS = 2'd0,
    CFG_WAIT_TICKS  = 2'd1,
    CFG_MASTER_MODE = 2'd2
  } cfg_addr_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_RECV = 3'b100
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] guard_ticks;
    logic [TickW-1:0] wait_ticks;
    logic             master_mode;
  } cfg_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [LenW-1:0]   frame_length;
    logic              busy_res;
  } result_t;

  // Reflected CRC-16, one byte, eight shift steps.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                                input logic [ByteW-1:0] data);
    logic [CrcW-1:0] crc;
    crc = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtu_frame_receiver.sv
// ----------------------------------------------------------------------------
// RTU frame receiver
// Receive side of a serial RTU link: frame timing, byte count and CRC check.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries requests from the line interface: tuser holds
//   the request (tick, byte, line error, start, stop), tdata the received byte.
//   Master stream (m_*) returns one result per request: tuser holds the event
//   (none, frame good, frame bad, wait timeout, line error), tdata the frame
//   length and the busy flag.
//   A result is offered on m_* from the output register: the frame update
//   runs while the request sits in the input register, and its result
//   lands in the output register when the request is taken. Throughput:
//   one item per cycle while m_tready is high, set by the combinational
//   frame update including a full byte of CRC-16.
//   Reset clears the frame state to idle, the registers to their defaults and
//   both stream stages to empty; s_tready stays low while reset is high.
//   When the receiver holds m_tready low the output register holds its item,
//   the input register fills, and then s_tready drops; nothing is lost.
//   Configuration writes on cfg_* take effect at the next edge; issue them
//   only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rtu_frame_receiver #(
  parameter int MAX_FRAME = rtu_pkg::MaxFrameDefault,
  parameter int MIN_FRAME = rtu_pkg::MinFrameDefault
) (
  input  wire                          clk,
  input  wire                          rst,
  // configuration write port
  input  wire                          cfg_we,
  input  wire [rtu_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire [rtu_pkg::CfgDataW-1:0]  cfg_wdata,
  // request stream
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [7:0]                    s_tdata,   // [7:0] data_byte
  input  wire [2:0]                    s_tuser,   // [2:0] req_type
  // result stream
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [15:0]                  m_tdata,   // [8:0] frame_length, [9] busy_res
  output logic [2:0]                   m_tuser    // [2:0] event_res
);
  import rtu_pkg::*;

  cfg_t              cfg;
  result_t           res;
  result_t           res_q;

  logic              in_valid;
  logic [ReqW-1:0]   req_q;
  logic [ByteW-1:0]  byte_q;
  logic              step;

  // Advance the held request when the output register is free or draining.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!in_valid || step);

  rtu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rtu_frame_core #(
    .MAX_FRAME (MAX_FRAME),
    .MIN_FRAME (MIN_FRAME)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .req_type  (req_q),
    .data_byte (byte_q),
    .cfg       (cfg),
    .res       (res)
  );

  // Input register: hold the request until the frame update takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q  <= s_tuser[ReqW-1:0];
      byte_q <= s_tdata[ByteW-1:0];
    end
  end

  // Output register: hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tuser = res_q.event_res;
  assign m_tdata = {{(16-LenW-1){1'b0}}, res_q.busy_res, res_q.frame_length};

endmodule

`default_nettype wire

// File: hw/rtl/rtu_cfg_regs.sv
// ----------------------------------------------------------------------------
// RTU receiver configuration registers
// Guard time, first-byte wait time and master/slave mode, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module rtu_cfg_regs (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [rtu_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire [rtu_pkg::CfgDataW-1:0]  cfg_wdata,
  output rtu_pkg::cfg_t                cfg
);
  import rtu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guard_ticks <= 16'd4;
      cfg.wait_ticks  <= 16'd1000;
      cfg.master_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GUARD_TICKS: cfg.guard_ticks <= cfg_wdata[TickW-1:0];
        CFG_WAIT_TICKS:  cfg.wait_ticks  <= cfg_wdata[TickW-1:0];
        CFG_MASTER_MODE: cfg.master_mode <= cfg_wdata[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rtu_frame_core.sv
// ----------------------------------------------------------------------------
// RTU receiver frame core
// Frame state (phase, byte count, silence count, CRC) and the per-item update.
// ----------------------------------------------------------------------------
`default_nettype none

module rtu_frame_core #(
  parameter int MAX_FRAME = rtu_pkg::MaxFrameDefault,
  parameter int MIN_FRAME = rtu_pkg::MinFrameDefault
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        step,
  input  wire [rtu_pkg::ReqW-1:0]    req_type,
  input  wire [rtu_pkg::ByteW-1:0]   data_byte,
  input  wire rtu_pkg::cfg_t         cfg,
  output rtu_pkg::result_t           res
);
  import rtu_pkg::*;

  localparam logic [LenW-1:0] MaxCount = LenW'(MAX_FRAME);
  localparam logic [LenW-1:0] MinCount = LenW'(MIN_FRAME);

  phase_t            phase, phase_next;
  logic [LenW-1:0]   byte_count, byte_count_next;
  logic [TickW-1:0]  quiet_ticks, quiet_ticks_next;
  logic [CrcW-1:0]   running_crc, running_crc_next;

  logic [TickW-1:0]  quiet_inc;
  logic              active;

  assign quiet_inc = (quiet_ticks == TickMax) ? quiet_ticks : quiet_ticks + 1'b1;
  assign active    = (phase == PH_WAIT) || (phase == PH_RECV);

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    quiet_ticks_next = quiet_ticks;
    running_crc_next = running_crc;
    res.event_res    = EV_NONE;
    res.frame_length = '0;

    unique case (req_type)
      REQ_TICK: begin
        if (active) begin
          quiet_ticks_next = quiet_inc;
          if (phase == PH_WAIT) begin
            if (quiet_inc >= cfg.wait_ticks) begin
              res.event_res = EV_WAIT_TIMEOUT;
            end
          end else if (quiet_inc >= cfg.guard_ticks) begin
            res.frame_length = byte_count;
            res.event_res    = (byte_count >= MinCount && running_crc == '0) ?
                               EV_GOOD : EV_BAD;
          end
        end
      end
      REQ_BYTE: begin
        if (active) begin
          if (byte_count < MaxCount) begin
            byte_count_next  = byte_count + 1'b1;
            running_crc_next = crc_byte(running_crc, data_byte);
          end
          quiet_ticks_next = '0;
          phase_next       = PH_RECV;
        end
      end
      REQ_ERROR: begin
        if (active) begin
          res.frame_length = byte_count;
          res.event_res    = EV_LINE_ERROR;
        end
      end
      REQ_START: begin
        phase_next       = PH_WAIT;
        byte_count_next  = '0;
        quiet_ticks_next = '0;
        running_crc_next = CrcInit;
      end
      REQ_STOP: begin
        phase_next       = PH_IDLE;
        byte_count_next  = '0;
        quiet_ticks_next = '0;
        running_crc_next = CrcInit;
      end
      default: ;  // ignore unknown codes
    endcase

    // Any outcome ends the frame: re-arm in slave mode, go idle in master mode.
    if (res.event_res != EV_NONE) begin
      if (cfg.master_mode) begin
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_WAIT;
      end
      byte_count_next  = '0;
      quiet_ticks_next = '0;
      running_crc_next = CrcInit;
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_count  <= '0;
      quiet_ticks <= '0;
      running_crc <= CrcInit;
    end else if (step) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      quiet_ticks <= quiet_ticks_next;
      running_crc <= running_crc_next;
    end
  end

endmodule

`default_nettype wire
